// ----- rtl/mhsa_pkg.sv -----
package mhsa_pkg;

   localparam int DATA_W        = 16;
   localparam int SEQ_MAX_DEF   = 16;
   localparam int EMBED_DIM_DEF = 64;
   localparam int NUM_HEADS_DEF = 4;
   localparam int CELL_W        = 18;

   typedef struct packed {
      logic              shift;
      logic [CELL_W-1:0] data;
   } chain_ctrl_type;

   function automatic logic [16:0] exp_whole(input logic [6:0] n);
      logic [16:0] w;
      unique case (n)
         7'd0:    w = 17'd65536;
         7'd1:    w = 17'd24109;
         7'd2:    w = 17'd8869;
         7'd3:    w = 17'd3263;
         7'd4:    w = 17'd1200;
         7'd5:    w = 17'd442;
         7'd6:    w = 17'd162;
         7'd7:    w = 17'd60;
         7'd8:    w = 17'd22;
         7'd9:    w = 17'd8;
         7'd10:   w = 17'd3;
         7'd11:   w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

   function automatic logic [16:0] exp_frac(input logic [3:0] f);
      logic [16:0] w;
      unique case (f)
         4'd0:  w = 17'd65536;
         4'd1:  w = 17'd61565;
         4'd2:  w = 17'd57835;
         4'd3:  w = 17'd54331;
         4'd4:  w = 17'd51039;
         4'd5:  w = 17'd47947;
         4'd6:  w = 17'd45042;
         4'd7:  w = 17'd42313;
         4'd8:  w = 17'd39750;
         4'd9:  w = 17'd37341;
         4'd10: w = 17'd35079;
         4'd11: w = 17'd32954;
         4'd12: w = 17'd30957;
         4'd13: w = 17'd29081;
         4'd14: w = 17'd27319;
         4'd15: w = 17'd25664;
      endcase
      return w;
   endfunction

   function automatic int unsigned inv_sqrt_scale(input int unsigned hd);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t * 64'(hd) <= (64'd1 << 32)) r = t;
      end
      return 32'(r);
   endfunction

endpackage

// ----- rtl/mhsa_cell.sv -----
module mhsa_cell (
   input  logic                          clock,
   input  logic                          shift,
   input  logic [mhsa_pkg::CELL_W-1:0]   d_in,
   output logic [mhsa_pkg::CELL_W-1:0]   q
);

   logic [mhsa_pkg::CELL_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift) value_ff <= d_in;
   end

   assign q = value_ff;

endmodule

// ----- rtl/mhsa_chain.sv -----
module mhsa_chain #(
   parameter int DEPTH = mhsa_pkg::SEQ_MAX_DEF
) (
   input  logic                          clock,
   input  mhsa_pkg::chain_ctrl_type      ctrl,
   input  logic [$clog2(DEPTH)-1:0]      tap_sel,
   output logic [mhsa_pkg::CELL_W-1:0]   tap
);

   logic [mhsa_pkg::CELL_W-1:0] cell_q [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [mhsa_pkg::CELL_W-1:0] d_in;
      if (k == DEPTH - 1) begin : g_tail
         assign d_in = ctrl.data;
      end else begin : g_link
         assign d_in = cell_q[k+1];
      end
      mhsa_cell u_cell (
         .clock (clock),
         .shift (ctrl.shift),
         .d_in  (d_in),
         .q     (cell_q[k])
      );
   end

   assign tap = cell_q[tap_sel];

endmodule

// ----- rtl/mhsa_div.sv -----
module mhsa_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_t;
   logic             qbit;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_t   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      qbit    = (rem_t >= {1'b0, den_ff});
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CW'(NUM_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = qbit ? rem_t - {1'b0, den_ff} : rem_t;
         num_in = {num_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ----- rtl/multi_head_self_attention.sv -----
// Multi-head scaled dot-product self-attention layer, signed Q5.10.
// Command channel: an item transfers at a rising edge with start high and
// busy low. Commands: load weight/bias word, load input element, run layer,
// read result element.
// Loads never raise busy; a load to an index outside its store is dropped.
// A read returns its result on the rsp_ ports in the cycle after the transfer,
// marked by rsp_valid for exactly one cycle; the receiver cannot stall and
// reads may follow back to back.
// A run holds busy high while one multiply-accumulate unit walks the layer,
// one product per cycle in its issue states: the Q, K and V projections,
// then per head and position the scores, softmax and value sums, then the
// output projection, with the score row kept in a rotating chain of cells
// and each softmax weight taken from a bit-serial 34-step divider. A run of
// length zero returns at once.
// Reset clears the sequencer, the run length and the response strobe; the
// weight, input and scratch memories hold whatever was last written.
module multi_head_self_attention #(
   parameter int SEQ_MAX   = mhsa_pkg::SEQ_MAX_DEF,
   parameter int EMBED_DIM = mhsa_pkg::EMBED_DIM_DEF,
   parameter int NUM_HEADS = mhsa_pkg::NUM_HEADS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_matrix_select,
   input  logic [1:0]         req_head_index,
   input  logic [5:0]         req_row_index,
   input  logic [5:0]         req_col_index,
   input  logic signed [15:0] req_data_value,
   input  logic [4:0]         req_seq_len,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_result_value,
   output logic               rsp_index_error
);

   localparam int HD    = EMBED_DIM / NUM_HEADS;
   localparam int X_D   = SEQ_MAX * EMBED_DIM;
   localparam int W_D   = NUM_HEADS * EMBED_DIM * HD;
   localparam int S_D   = NUM_HEADS * SEQ_MAX * HD;
   localparam int PW_D  = EMBED_DIM * EMBED_DIM;
   localparam int X_AW  = $clog2(X_D);
   localparam int W_AW  = (W_D > 1) ? $clog2(W_D) : 1;
   localparam int S_AW  = (S_D > 1) ? $clog2(S_D) : 1;
   localparam int PW_AW = $clog2(PW_D);
   localparam int PB_AW = $clog2(EMBED_DIM);
   localparam int HW    = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
   localparam int IW    = $clog2(SEQ_MAX);
   localparam int DW    = (HD > 1) ? $clog2(HD) : 1;
   localparam int TW    = $clog2((EMBED_DIM > SEQ_MAX) ? EMBED_DIM : SEQ_MAX);
   localparam int LEN_W = $clog2(SEQ_MAX + 1);
   localparam int ACC_W = 2 * mhsa_pkg::DATA_W + 3 + $clog2(EMBED_DIM) + $clog2(SEQ_MAX);
   localparam int TOT_W = ACC_W + 19;
   localparam int SUM_W = 17 + $clog2(SEQ_MAX);
   localparam int NUM_W = 34;
   localparam logic [16:0] SCALE = 17'(mhsa_pkg::inv_sqrt_scale(HD));

   localparam logic [1:0] CMD_LOAD_W = 2'd0;
   localparam logic [1:0] CMD_LOAD_X = 2'd1;
   localparam logic [1:0] CMD_RUN    = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;
   localparam logic [2:0] SEL_Q      = 3'd0;
   localparam logic [2:0] SEL_K      = 3'd1;
   localparam logic [2:0] SEL_V      = 3'd2;
   localparam logic [2:0] SEL_PW     = 3'd3;
   localparam logic [2:0] SEL_PB     = 3'd4;
   localparam logic [1:0] MAT_Q      = 2'd0;
   localparam logic [1:0] MAT_K      = 2'd1;
   localparam logic [1:0] MAT_V      = 2'd2;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_QKV_ISS = 5'd1;
   localparam logic [4:0] ST_QKV_DRN = 5'd2;
   localparam logic [4:0] ST_QKV_FIN = 5'd3;
   localparam logic [4:0] ST_SC_ISS  = 5'd4;
   localparam logic [4:0] ST_SC_DRN  = 5'd5;
   localparam logic [4:0] ST_SC_MUL  = 5'd6;
   localparam logic [4:0] ST_SC_FIN  = 5'd7;
   localparam logic [4:0] ST_MAX     = 5'd8;
   localparam logic [4:0] ST_EXA     = 5'd9;
   localparam logic [4:0] ST_EXB     = 5'd10;
   localparam logic [4:0] ST_DVGO    = 5'd11;
   localparam logic [4:0] ST_DVW     = 5'd12;
   localparam logic [4:0] ST_PV_ISS  = 5'd13;
   localparam logic [4:0] ST_PV_DRN  = 5'd14;
   localparam logic [4:0] ST_PV_FIN  = 5'd15;
   localparam logic [4:0] ST_PJ_BIAS = 5'd16;
   localparam logic [4:0] ST_PJ_ISS  = 5'd17;
   localparam logic [4:0] ST_PJ_DRN  = 5'd18;
   localparam logic [4:0] ST_PJ_FIN  = 5'd19;

   function automatic logic signed [15:0] sat_round(input logic signed [95:0] v, input int s);
      logic signed [95:0] r;
      r = (v + (96'sd1 <<< (s - 1))) >>> s;
      if (r > 96'sd32767) return 16'sh7fff;
      else if (r < -96'sd32768) return 16'sh8000;
      return r[15:0];
   endfunction

   logic signed [15:0] x_mem  [X_D];
   logic signed [15:0] wq_mem [W_D];
   logic signed [15:0] wk_mem [W_D];
   logic signed [15:0] wv_mem [W_D];
   logic signed [15:0] pw_mem [PW_D];
   logic signed [15:0] pb_mem [EMBED_DIM];
   logic signed [15:0] q_mem  [S_D];
   logic signed [15:0] k_mem  [S_D];
   logic signed [15:0] v_mem  [S_D];
   logic signed [15:0] cc_mem [X_D];
   logic signed [15:0] rs_mem [X_D];

   logic signed [15:0] x_rd_ff, wq_rd_ff, wk_rd_ff, wv_rd_ff, pw_rd_ff, pb_rd_ff;
   logic signed [15:0] q_rd_ff, k_rd_ff, v_rd_ff, cc_rd_ff, rs_rd_ff;
   logic signed [17:0] p_rd_ff;

   logic [4:0]       state_ff, state_in;
   logic [1:0]       cm_ff, cm_in;
   logic [HW-1:0]    ch_ff, ch_in;
   logic [IW-1:0]    ci_ff, ci_in;
   logic [TW-1:0]    cj_ff, cj_in;
   logic [DW-1:0]    cd_ff, cd_in;
   logic [TW-1:0]    ct_ff, ct_in;
   logic             drn_ff, drn_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic signed [15:0] mx_ff, mx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             v1_ff, v2_ff;
   logic signed [33:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [36:0] pp_lo_ff;
   logic signed [ACC_W-1:0] pp_hi_ff;
   logic [33:0]      expp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             err_ff, err_in;

   logic             accept, load_w, iss;
   logic [LEN_W-1:0] run_len, len_m1;
   logic [TW-1:0]    tlim;
   logic             t_last, n_last, i_last, h_last, d_last, e_last, j_last;
   logic signed [17:0] opa;
   logic signed [15:0] opb;
   logic [TOT_W-1:0] total;
   logic signed [15:0] score, acc_r10, acc_r16;
   logic [mhsa_pkg::CELL_W-1:0] tap;
   logic signed [15:0] tap_s;
   logic signed [16:0] diff;
   logic [33:0]      exp_round;
   logic [16:0]      e_val;
   mhsa_pkg::chain_ctrl_type chain_ctrl;
   logic [IW-1:0]    tap_sel;
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quot;

   logic [31:0] a_wl, a_pw_l, a_x_l, a_rs_r;
   logic [31:0] a_x_r, a_w_r, a_q_r, a_k_r, a_v_r, a_cc_r, a_pw_r;
   logic [31:0] a_s_w, a_cc_w, a_rs_w, a_tap;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign load_w = accept && (req_command == CMD_LOAD_W);
   assign iss    = (state_ff == ST_QKV_ISS) || (state_ff == ST_SC_ISS) ||
                   (state_ff == ST_PV_ISS) || (state_ff == ST_PJ_ISS);

   assign run_len = (32'(req_seq_len) > 32'(SEQ_MAX)) ? LEN_W'(SEQ_MAX) : LEN_W'(req_seq_len);
   assign len_m1  = len_ff - 1'b1;

   always_comb begin
      a_wl   = (32'(req_head_index) * 32'(EMBED_DIM) + 32'(req_row_index)) * 32'(HD) +
               32'(req_col_index);
      a_pw_l = 32'(req_row_index) * 32'(EMBED_DIM) + 32'(req_col_index);
      a_x_l  = a_pw_l;
      a_rs_r = a_pw_l;
      a_x_r  = 32'(ci_ff) * 32'(EMBED_DIM) + 32'(ct_ff);
      a_w_r  = (32'(ch_ff) * 32'(EMBED_DIM) + 32'(ct_ff)) * 32'(HD) + 32'(cd_ff);
      a_q_r  = (32'(ch_ff) * 32'(SEQ_MAX) + 32'(ci_ff)) * 32'(HD) + 32'(ct_ff);
      a_k_r  = (32'(ch_ff) * 32'(SEQ_MAX) + 32'(cj_ff)) * 32'(HD) + 32'(ct_ff);
      a_v_r  = (32'(ch_ff) * 32'(SEQ_MAX) + 32'(ct_ff)) * 32'(HD) + 32'(cd_ff);
      a_cc_r = a_x_r;
      a_pw_r = 32'(ct_ff) * 32'(EMBED_DIM) + 32'(cj_ff);
      a_s_w  = (32'(ch_ff) * 32'(SEQ_MAX) + 32'(ci_ff)) * 32'(HD) + 32'(cd_ff);
      a_cc_w = 32'(ci_ff) * 32'(EMBED_DIM) + 32'(ch_ff) * 32'(HD) + 32'(cd_ff);
      a_rs_w = 32'(ci_ff) * 32'(EMBED_DIM) + 32'(cj_ff);
      a_tap  = 32'(SEQ_MAX) - 32'(len_ff);
   end

   logic w_qkv_ok, w_pw_ok, w_pb_ok, x_ok;
   assign w_qkv_ok = (32'(req_head_index) < 32'(NUM_HEADS)) &&
                     (32'(req_row_index) < 32'(EMBED_DIM)) && (32'(req_col_index) < 32'(HD));
   assign w_pw_ok  = (32'(req_row_index) < 32'(EMBED_DIM)) &&
                     (32'(req_col_index) < 32'(EMBED_DIM));
   assign w_pb_ok  = (32'(req_col_index) < 32'(EMBED_DIM));
   assign x_ok     = (32'(req_row_index) < 32'(SEQ_MAX)) && w_pb_ok;

   assign acc_r10 = sat_round(96'(acc_ff), 10);
   assign acc_r16 = sat_round(96'(acc_ff), 16);

   always_ff @(posedge clock) begin
      if (load_w && req_matrix_select == SEL_Q && w_qkv_ok)
         wq_mem[a_wl[W_AW-1:0]] <= req_data_value;
      if (load_w && req_matrix_select == SEL_K && w_qkv_ok)
         wk_mem[a_wl[W_AW-1:0]] <= req_data_value;
      if (load_w && req_matrix_select == SEL_V && w_qkv_ok)
         wv_mem[a_wl[W_AW-1:0]] <= req_data_value;
      if (load_w && req_matrix_select == SEL_PW && w_pw_ok)
         pw_mem[a_pw_l[PW_AW-1:0]] <= req_data_value;
      if (load_w && req_matrix_select == SEL_PB && w_pb_ok)
         pb_mem[req_col_index[PB_AW-1:0]] <= req_data_value;
      if (accept && req_command == CMD_LOAD_X && x_ok)
         x_mem[a_x_l[X_AW-1:0]] <= req_data_value;
      if (state_ff == ST_QKV_FIN && cm_ff == MAT_Q) q_mem[a_s_w[S_AW-1:0]] <= acc_r10;
      if (state_ff == ST_QKV_FIN && cm_ff == MAT_K) k_mem[a_s_w[S_AW-1:0]] <= acc_r10;
      if (state_ff == ST_QKV_FIN && cm_ff == MAT_V) v_mem[a_s_w[S_AW-1:0]] <= acc_r10;
      if (state_ff == ST_PV_FIN) cc_mem[a_cc_w[X_AW-1:0]] <= acc_r16;
      if (state_ff == ST_PJ_FIN) rs_mem[a_rs_w[X_AW-1:0]] <= acc_r10;
      x_rd_ff  <= x_mem[a_x_r[X_AW-1:0]];
      wq_rd_ff <= wq_mem[a_w_r[W_AW-1:0]];
      wk_rd_ff <= wk_mem[a_w_r[W_AW-1:0]];
      wv_rd_ff <= wv_mem[a_w_r[W_AW-1:0]];
      pw_rd_ff <= pw_mem[a_pw_r[PW_AW-1:0]];
      pb_rd_ff <= pb_mem[cj_ff[PB_AW-1:0]];
      q_rd_ff  <= q_mem[a_q_r[S_AW-1:0]];
      k_rd_ff  <= k_mem[a_k_r[S_AW-1:0]];
      v_rd_ff  <= v_mem[a_v_r[S_AW-1:0]];
      cc_rd_ff <= cc_mem[a_cc_r[X_AW-1:0]];
      rs_rd_ff <= rs_mem[a_rs_r[X_AW-1:0]];
   end

   assign tap_s   = signed'(tap[15:0]);
   assign tap_sel = a_tap[IW-1:0];

   mhsa_chain #(.DEPTH(SEQ_MAX)) u_chain (
      .clock   (clock),
      .ctrl    (chain_ctrl),
      .tap_sel (tap_sel),
      .tap     (tap)
   );

   assign div_num = NUM_W'({tap[16:0], 16'b0}) + NUM_W'(sum_ff >> 1);

   mhsa_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (sum_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      opa = 18'(x_rd_ff);
      opb = wq_rd_ff;
      if (state_ff == ST_QKV_ISS || state_ff == ST_QKV_DRN) begin
         opa = 18'(x_rd_ff);
         opb = (cm_ff == MAT_Q) ? wq_rd_ff : ((cm_ff == MAT_K) ? wk_rd_ff : wv_rd_ff);
      end else if (state_ff == ST_SC_ISS || state_ff == ST_SC_DRN) begin
         opa = 18'(q_rd_ff);
         opb = k_rd_ff;
      end else if (state_ff == ST_PV_ISS || state_ff == ST_PV_DRN) begin
         opa = p_rd_ff;
         opb = v_rd_ff;
      end else if (state_ff == ST_PJ_ISS || state_ff == ST_PJ_DRN) begin
         opa = 18'(cc_rd_ff);
         opb = pw_rd_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (iss && ct_ff == '0)
         acc_in = (state_ff == ST_PJ_ISS) ? (ACC_W'(pb_rd_ff) <<< 10) : '0;
      else if (v2_ff)
         acc_in = acc_ff + ACC_W'(prod_ff);
   end

   assign total     = (TOT_W'(pp_hi_ff) <<< 18) + TOT_W'(pp_lo_ff);
   assign score     = sat_round(96'(signed'(total)), 26);
   assign diff      = 17'(mx_ff) - 17'(tap_s);
   assign exp_round = expp_ff + 34'd32768;
   assign e_val     = exp_round[32:16];

   always_comb begin
      unique case (state_ff)
         ST_QKV_ISS: tlim = TW'(EMBED_DIM - 1);
         ST_SC_ISS:  tlim = TW'(HD - 1);
         ST_PV_ISS:  tlim = TW'(len_m1);
         default:    tlim = TW'(EMBED_DIM - 1);
      endcase
   end

   assign t_last = (ct_ff == tlim);
   assign n_last = (ct_ff == TW'(len_m1));
   assign j_last = (cj_ff == TW'(len_m1));
   assign e_last = (cj_ff == TW'(EMBED_DIM - 1));
   assign i_last = (LEN_W'(ci_ff) == len_m1);
   assign h_last = (ch_ff == HW'(NUM_HEADS - 1));
   assign d_last = (cd_ff == DW'(HD - 1));

   always_comb begin
      chain_ctrl.shift = 1'b0;
      chain_ctrl.data  = tap;
      unique case (state_ff)
         ST_SC_FIN: begin
            chain_ctrl.shift = 1'b1;
            chain_ctrl.data  = mhsa_pkg::CELL_W'(score);
         end
         ST_MAX, ST_PV_ISS: chain_ctrl.shift = 1'b1;
         ST_EXB: begin
            chain_ctrl.shift = 1'b1;
            chain_ctrl.data  = {1'b0, e_val};
         end
         ST_DVW: begin
            chain_ctrl.shift = div_done;
            chain_ctrl.data  = div_quot[mhsa_pkg::CELL_W-1:0];
         end
         default: chain_ctrl.shift = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cm_in     = cm_ff;
      ch_in     = ch_ff;
      ci_in     = ci_ff;
      cj_in     = cj_ff;
      cd_in     = cd_ff;
      ct_in     = ct_ff;
      drn_in    = drn_ff;
      len_in    = len_ff;
      mx_in     = mx_ff;
      sum_in    = sum_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_RUN) begin
               len_in = run_len;
               cm_in  = MAT_Q;
               ch_in  = '0;
               ci_in  = '0;
               cd_in  = '0;
               ct_in  = '0;
               if (run_len != '0) state_in = ST_QKV_ISS;
            end
         end
         ST_QKV_ISS, ST_SC_ISS, ST_PV_ISS, ST_PJ_ISS: begin
            ct_in = ct_ff + 1'b1;
            if (t_last) begin
               ct_in  = '0;
               drn_in = 1'b0;
               state_in = state_ff + 5'd1;
            end
         end
         ST_QKV_DRN, ST_SC_DRN, ST_PV_DRN, ST_PJ_DRN: begin
            drn_in = 1'b1;
            if (drn_ff) state_in = state_ff + 5'd1;
         end
         ST_QKV_FIN: begin
            state_in = ST_QKV_ISS;
            if (!d_last) cd_in = cd_ff + 1'b1;
            else begin
               cd_in = '0;
               if (!i_last) ci_in = ci_ff + 1'b1;
               else begin
                  ci_in = '0;
                  if (!h_last) ch_in = ch_ff + 1'b1;
                  else begin
                     ch_in = '0;
                     if (cm_ff != MAT_V) cm_in = cm_ff + 1'b1;
                     else begin
                        cj_in    = '0;
                        state_in = ST_SC_ISS;
                     end
                  end
               end
            end
         end
         ST_SC_MUL: state_in = ST_SC_FIN;
         ST_SC_FIN: begin
            if (j_last) begin
               cj_in    = '0;
               ct_in    = '0;
               state_in = ST_MAX;
            end else begin
               cj_in    = cj_ff + 1'b1;
               state_in = ST_SC_ISS;
            end
         end
         ST_MAX: begin
            if (ct_ff == '0 || tap_s > mx_ff) mx_in = tap_s;
            ct_in = ct_ff + 1'b1;
            if (n_last) begin
               ct_in    = '0;
               sum_in   = '0;
               state_in = ST_EXA;
            end
         end
         ST_EXA: state_in = ST_EXB;
         ST_EXB: begin
            sum_in   = sum_ff + SUM_W'(e_val);
            ct_in    = ct_ff + 1'b1;
            state_in = ST_EXA;
            if (n_last) begin
               ct_in    = '0;
               state_in = ST_DVGO;
            end
         end
         ST_DVGO: begin
            div_start = 1'b1;
            state_in  = ST_DVW;
         end
         ST_DVW: begin
            if (div_done) begin
               ct_in    = ct_ff + 1'b1;
               state_in = ST_DVGO;
               if (n_last) begin
                  ct_in    = '0;
                  cd_in    = '0;
                  state_in = ST_PV_ISS;
               end
            end
         end
         ST_PV_FIN: begin
            state_in = ST_PV_ISS;
            if (!d_last) cd_in = cd_ff + 1'b1;
            else begin
               cd_in    = '0;
               cj_in    = '0;
               state_in = ST_SC_ISS;
               if (!i_last) ci_in = ci_ff + 1'b1;
               else begin
                  ci_in = '0;
                  if (!h_last) ch_in = ch_ff + 1'b1;
                  else begin
                     ch_in    = '0;
                     state_in = ST_PJ_BIAS;
                  end
               end
            end
         end
         ST_PJ_BIAS: state_in = ST_PJ_ISS;
         ST_PJ_FIN: begin
            state_in = ST_PJ_BIAS;
            if (!e_last) cj_in = cj_ff + 1'b1;
            else begin
               cj_in = '0;
               if (!i_last) ci_in = ci_ff + 1'b1;
               else begin
                  ci_in    = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = accept && (req_command == CMD_READ);
   assign err_in = !((32'(req_row_index) < 32'(len_ff)) && w_pb_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         cm_ff        <= MAT_Q;
         ch_ff        <= '0;
         ci_ff        <= '0;
         cj_ff        <= '0;
         cd_ff        <= '0;
         ct_ff        <= '0;
         drn_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= iss;
         v2_ff        <= v1_ff;
         cm_ff        <= cm_in;
         ch_ff        <= ch_in;
         ci_ff        <= ci_in;
         cj_ff        <= cj_in;
         cd_ff        <= cd_in;
         ct_ff        <= ct_in;
         drn_ff       <= drn_in;
      end
      mx_ff    <= mx_in;
      sum_ff   <= sum_in;
      acc_ff   <= acc_in;
      prod_ff  <= opa * opb;
      p_rd_ff  <= signed'(tap);
      pp_lo_ff <= $signed({1'b0, acc_ff[17:0]}) * $signed({1'b0, SCALE});
      pp_hi_ff <= ACC_W'($signed(acc_ff[ACC_W-1:18]) * $signed({1'b0, SCALE}));
      expp_ff  <= 34'(mhsa_pkg::exp_whole(diff[16:10])) * 34'(mhsa_pkg::exp_frac(diff[9:6]));
      if (rsp_valid_in) err_ff <= err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_index_error  = err_ff;
   assign rsp_result_value = err_ff ? 16'sd0 : rs_rd_ff;

endmodule

// ----- bench/tb_multi_head_self_attention.sv -----
module tb_multi_head_self_attention;
   timeunit 1ns;
   timeprecision 1ps;

   import mhsa_pkg::*;

   typedef enum logic [1:0] {CMD_LOAD_W, CMD_LOAD_X, CMD_RUN, CMD_READ} cmd_e;
   typedef enum logic [2:0] {
      SEL_Q, SEL_K, SEL_V, SEL_PROJ, SEL_BIAS, SEL_BAD5, SEL_BAD6, SEL_BAD7
   } sel_e;

   localparam int EMB = EMBED_DIM_DEF;
   localparam int NH = NUM_HEADS_DEF;
   localparam int HD = EMB / NH;
   localparam int SMAX = SEQ_MAX_DEF;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int SETTLE = 20;

   typedef struct {
      cmd_e               cmd;
      sel_e               sel;
      logic [1:0]         head;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] val;
      logic [4:0]         len;
      int                 gap;
      bit                 drain;
   } cmd_item_t;

   typedef struct {
      logic signed [15:0] value;
      logic               err;
   } read_result_t;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = '0;
   logic [2:0]         req_matrix_select = '0;
   logic [1:0]         req_head_index = '0;
   logic [5:0]         req_row_index = '0;
   logic [5:0]         req_col_index = '0;
   logic signed [15:0] req_data_value = '0;
   logic [4:0]         req_seq_len = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_result_value;
   logic               rsp_index_error;

   multi_head_self_attention DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_matrix_select(req_matrix_select),
      .req_head_index(req_head_index), .req_row_index(req_row_index),
      .req_col_index(req_col_index), .req_data_value(req_data_value),
      .req_seq_len(req_seq_len), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value), .rsp_index_error(rsp_index_error)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // attention state mirror
   int query_w[NH*EMB*HD];
   int key_w[NH*EMB*HD];
   int value_w[NH*EMB*HD];
   int proj_w[EMB*EMB];
   int proj_b[EMB];
   int token_x[SMAX*EMB];
   int layer_out[SMAX*EMB];
   int run_len;
   int q_act[NH][SMAX][HD];
   int k_act[NH][SMAX][HD];
   int v_act[NH][SMAX][HD];
   int heads_cat[SMAX][EMB];
   longint score_scale;
   longint unsigned exp_w_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                      22, 8, 3, 1};
   longint unsigned exp_f_tab[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                      42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                      27319, 25664};

   cmd_item_t    pending_cmds[$];
   read_result_t pending_reads[$];
   cmd_item_t    cur;
   int           idle_left = 0;
   int           errors = 0;
   int           reads_checked = 0;
   int           runs_done = 0;
   int           accepted = 0;
   longint       cycles = 0;
   bit           use_gaps = 1;

   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic int sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   task automatic run_attention(int n);
      longint acc;
      int sc[SMAX];
      longint unsigned ex[SMAX];
      longint unsigned tot;
      longint unsigned p;
      longint unsigned dlt;
      int mx;
      for (int h = 0; h < NH; h++)
         for (int i = 0; i < n; i++)
            for (int d = 0; d < HD; d++) begin
               for (int m = 0; m < 3; m++) begin
                  acc = 0;
                  for (int j = 0; j < EMB; j++) begin
                     case (m)
                        0: acc += longint'(token_x[i*EMB+j]) * query_w[(h*EMB+j)*HD+d];
                        1: acc += longint'(token_x[i*EMB+j]) * key_w[(h*EMB+j)*HD+d];
                        default: acc += longint'(token_x[i*EMB+j]) * value_w[(h*EMB+j)*HD+d];
                     endcase
                  end
                  case (m)
                     0: q_act[h][i][d] = sat16(round_shr(acc, 10));
                     1: k_act[h][i][d] = sat16(round_shr(acc, 10));
                     default: v_act[h][i][d] = sat16(round_shr(acc, 10));
                  endcase
               end
            end
      for (int h = 0; h < NH; h++)
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               acc = 0;
               for (int d = 0; d < HD; d++)
                  acc += longint'(q_act[h][i][d]) * k_act[h][j][d];
               sc[j] = sat16(round_shr(acc * score_scale, 26));
            end
            mx = sc[0];
            for (int j = 1; j < n; j++)
               if (sc[j] > mx) mx = sc[j];
            tot = 0;
            for (int j = 0; j < n; j++) begin
               dlt = longint'(mx - sc[j]);
               if ((dlt >> 10) >= 12) ex[j] = 0;
               else ex[j] = (exp_w_tab[dlt >> 10] * exp_f_tab[(dlt >> 6) & 15] + 32768) >> 16;
               tot += ex[j];
            end
            for (int d = 0; d < HD; d++) begin
               acc = 0;
               for (int j = 0; j < n; j++) begin
                  p = ((ex[j] << 16) + tot / 2) / tot;
                  acc += longint'(p) * v_act[h][j][d];
               end
               heads_cat[i][h*HD+d] = sat16(round_shr(acc, 16));
            end
         end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < EMB; j++) begin
            acc = longint'(proj_b[j]) * 1024;
            for (int k = 0; k < EMB; k++)
               acc += longint'(heads_cat[i][k]) * proj_w[k*EMB+j];
            layer_out[i*EMB+j] = sat16(round_shr(acc, 10));
         end
   endtask

   task automatic attention_apply(cmd_item_t it);
      read_result_t r;
      int len;
      case (it.cmd)
         CMD_LOAD_W: begin
            if (it.sel <= SEL_V) begin
               if (it.col < HD) begin
                  case (it.sel)
                     SEL_Q: query_w[(it.head*EMB+it.row)*HD+it.col] = it.val;
                     SEL_K: key_w[(it.head*EMB+it.row)*HD+it.col] = it.val;
                     default: value_w[(it.head*EMB+it.row)*HD+it.col] = it.val;
                  endcase
               end
            end else if (it.sel == SEL_PROJ) begin
               proj_w[it.row*EMB+it.col] = it.val;
            end else if (it.sel == SEL_BIAS) begin
               proj_b[it.col] = it.val;
            end
         end
         CMD_LOAD_X: begin
            if (it.row < SMAX) token_x[it.row*EMB+it.col] = it.val;
         end
         CMD_RUN: begin
            len = (it.len > SMAX) ? SMAX : it.len;
            run_len = len;
            runs_done++;
            if (len > 0) run_attention(len);
         end
         default: begin
            if (it.row < run_len) begin
               r.value = layer_out[it.row*EMB+it.col][15:0];
               r.err = 1'b0;
            end else begin
               r.value = '0;
               r.err = 1'b1;
            end
            pending_reads.push_back(r);
         end
      endcase
   endtask

   task automatic report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      cmd_item_t nx;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            attention_apply(cur);
            accepted++;
         end
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].drain && pending_reads.size() > 0)) begin
            nx = pending_cmds.pop_front();
            cur <= nx;
            idle_left <= nx.gap;
            start <= 1'b1;
            req_command <= nx.cmd;
            req_matrix_select <= nx.sel;
            req_head_index <= nx.head;
            req_row_index <= nx.row;
            req_col_index <= nx.col;
            req_data_value <= nx.val;
            req_seq_len <= nx.len;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      read_result_t e;
      if (!reset && rsp_valid) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            e = pending_reads.pop_front();
            reads_checked++;
            if (rsp_result_value !== e.value)
               report_mismatch($sformatf("result_value got %0d want %0d",
                                         rsp_result_value, e.value));
            if (rsp_index_error !== e.err)
               report_mismatch($sformatf("index_error got %0b want %0b",
                                         rsp_index_error, e.err));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_multi_head_self_attention: FAIL");
         $finish;
      end
   end

   function automatic logic signed [15:0] rnd_word(int mag);
      if ($urandom_range(0, 7) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 2*mag) - mag);
   endfunction

   task automatic put(cmd_e c, sel_e s, int h, int r, int cl, int v, int l, bit dr = 0);
      cmd_item_t it;
      it.cmd = c;
      it.sel = s;
      it.head = h[1:0];
      it.row = r[5:0];
      it.col = cl[5:0];
      it.val = v[15:0];
      it.len = l[4:0];
      it.drain = dr;
      it.gap = (use_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      pending_cmds.push_back(it);
   endtask

   initial begin
      longint r;
      int pick;
      r = 0;
      for (int b = 16; b >= 0; b--)
         if (((r | (longint'(1) << b)) ** 2) * HD <= (longint'(1) << 32))
            r = r | (longint'(1) << b);
      score_scale = r;
      run_len = 0;

      // reads before any run, both corners
      put(CMD_READ, SEL_Q, 0, 0, 0, 0, 0);
      put(CMD_READ, SEL_Q, 3, 63, 63, -1, 31);
      // preload every store
      for (int s = 0; s < 3; s++)
         for (int h = 0; h < NH; h++)
            for (int rw = 0; rw < EMB; rw++)
               for (int c = 0; c < HD; c++)
                  put(CMD_LOAD_W, sel_e'(s), h, rw, c, $urandom_range(0, 1024) - 512, 0);
      for (int rw = 0; rw < EMB; rw++)
         for (int c = 0; c < EMB; c++)
            put(CMD_LOAD_W, SEL_PROJ, 0, rw, c, $urandom_range(0, 1024) - 512, 0);
      for (int c = 0; c < EMB; c++)
         put(CMD_LOAD_W, SEL_BIAS, $urandom_range(0, 3), 0, c,
             $urandom_range(0, 4096) - 2048, 0);
      for (int rw = 0; rw < SMAX; rw++)
         for (int c = 0; c < EMB; c++)
            put(CMD_LOAD_X, SEL_Q, 0, rw, c, $urandom_range(0, 2048) - 1024, 0);
      // ignored loads: out-of-range column, row, bad select
      put(CMD_LOAD_W, SEL_Q, 1, 5, 16, 32767, 0);
      put(CMD_LOAD_W, SEL_V, 2, 63, 63, -32768, 0);
      put(CMD_LOAD_W, SEL_BAD5, 0, 0, 0, 1234, 0);
      put(CMD_LOAD_W, SEL_BAD6, 1, 1, 1, -1234, 0);
      put(CMD_LOAD_W, SEL_BAD7, 3, 63, 63, 32767, 0);
      put(CMD_LOAD_X, SEL_Q, 0, 16, 0, 32767, 0);
      put(CMD_LOAD_X, SEL_Q, 0, 63, 63, -32768, 0);
      // length above the maximum saturates
      put(CMD_RUN, SEL_Q, 0, 0, 0, 0, 31);
      put(CMD_READ, SEL_Q, 0, 0, 0, 0, 0, 1);
      put(CMD_READ, SEL_Q, 0, 15, 63, 0, 0);
      put(CMD_READ, SEL_Q, 0, 16, 5, 0, 0);
      put(CMD_READ, SEL_Q, 0, 7, 31, 0, 0);
      // saturating extremes
      put(CMD_LOAD_X, SEL_Q, 0, 0, 0, 32767, 0);
      put(CMD_LOAD_X, SEL_Q, 0, 0, 63, -32768, 0);
      put(CMD_LOAD_W, SEL_Q, 0, 0, 0, 32767, 0);
      put(CMD_LOAD_W, SEL_K, 0, 63, 15, -32768, 0);
      put(CMD_LOAD_W, SEL_PROJ, 0, 63, 63, 32767, 0);
      put(CMD_LOAD_W, SEL_BIAS, 0, 0, 0, -32768, 0);
      put(CMD_RUN, SEL_Q, 0, 0, 0, 0, 1);
      put(CMD_READ, SEL_Q, 0, 0, 0, 0, 0);
      put(CMD_READ, SEL_Q, 0, 0, 63, 0, 0);
      put(CMD_READ, SEL_Q, 0, 1, 0, 0, 0);
      // zero length
      put(CMD_RUN, SEL_Q, 0, 0, 0, 0, 0);
      put(CMD_READ, SEL_Q, 0, 0, 0, 0, 0);

      for (int n = 0; n < 450; n++) begin
         if (n == 370) use_gaps = 0;
         pick = $urandom_range(0, 99);
         if (pick < 3 || n == 0) begin
            put(CMD_RUN, SEL_Q, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3),
                $urandom_range(0, 1));
         end else if (pick < 60) begin
            put(CMD_READ, sel_e'($urandom), $urandom, $urandom_range(0, 4), $urandom,
                $urandom, $urandom);
         end else if (pick < 65) begin
            put(CMD_READ, sel_e'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom);
         end else if (pick < 85) begin
            put(CMD_LOAD_W, sel_e'($urandom), $urandom, $urandom, $urandom,
                rnd_word(512), $urandom);
         end else begin
            put(CMD_LOAD_X, sel_e'($urandom), $urandom, $urandom_range(0, 17), $urandom,
                rnd_word(1024), $urandom);
         end
      end
      put(CMD_READ, SEL_Q, 0, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || start) @(posedge clock);
      while (pending_reads.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d command transfers, %0d layer runs, %0d reads checked",
               accepted, runs_done, reads_checked);
      $display("incl. saturated length, zero length, ignored loads, extreme words");
      if (errors == 0 && pending_reads.size() == 0) begin
         $display("tb_multi_head_self_attention: PASS");
      end else begin
         $display("tb_multi_head_self_attention: FAIL");
      end
      $finish;
   end

endmodule
